// ===== rtl/rmv_pkg.sv =====
`default_nettype none

package rmv_pkg;

   // sample counter and derived widths
   localparam int COUNT_BITS   = 24;
   localparam int CNT_OUT_BITS = 24;
   localparam int N1_W         = COUNT_BITS + 1;
   localparam int CMP_W        = (COUNT_BITS > CNT_OUT_BITS) ? COUNT_BITS : CNT_OUT_BITS;

   // configuration port
   localparam int LEVEL_W     = 19;
   localparam int MIN_W       = 24;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_A     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_B     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_SAMPLES = 2'd2;

   localparam logic [LEVEL_W-1:0] LEVEL_RESET = 19'd6554;
   localparam logic [MIN_W-1:0]   MIN_RESET   = 24'd100;

   // shared divider: 4 quotient bits per cycle
   localparam int DIV_W     = N1_W;
   localparam int DIV_STEPS = 4;
   localparam int DIV_CNT_W = 5;
   localparam logic [DIV_CNT_W-1:0] DIV_CYC_32 = DIV_CNT_W'(32 / DIV_STEPS);
   localparam logic [DIV_CNT_W-1:0] DIV_CYC_48 = DIV_CNT_W'(48 / DIV_STEPS);
   localparam logic [DIV_CNT_W-1:0] DIV_CYC_64 = DIV_CNT_W'(64 / DIV_STEPS);

   // square root: 2 root bits per cycle
   localparam int SQRT_STEPS = 2;
   localparam int SQRT_CNT_W = 5;
   localparam logic [SQRT_CNT_W-1:0] SQRT_CYCLES = SQRT_CNT_W'(32 / SQRT_STEPS);

   // shared multiplier
   localparam int MUL_B_W = (N1_W > 32) ? N1_W : 32;
   localparam int PROD_W  = 32 + MUL_B_W;
   localparam int TERM_W  = PROD_W + 33;

   // interval and precision constants
   localparam int HALF_MUL = 196;
   localparam int HALF_DIV = 100;
   localparam int HALF_W   = 34;
   localparam int P196_W   = 40;

   localparam logic signed [35:0] SAT_MAX = 36'sd2147483647;
   localparam logic signed [35:0] SAT_MIN = -36'sd2147483648;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_MEAN,
      ST_MUL_SQ,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_TERM,
      ST_DIV_KEEP,
      ST_ADD_VAR,
      ST_DIV_STD,
      ST_SQRT,
      ST_HALF_GO,
      ST_DIV_HALF,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [63:0]          dividend;
      logic [DIV_W-1:0]     divisor;
      logic [DIV_CNT_W-1:0] cycles;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] value;
   } sqrt_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] root;
   } sqrt_rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      if (v > SAT_MAX) begin
         return 32'sh7FFFFFFF;
      end else if (v < SAT_MIN) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/rmv_div.sv =====
`default_nettype none

module rmv_div (
   input  logic                 clock,
   input  logic                 reset,
   input  rmv_pkg::div_req_type div_req,
   output rmv_pkg::div_rsp_type div_rsp
);
   import rmv_pkg::*;

   logic [63:0]          num_ff, num_in;
   logic [DIV_W:0]       rem_ff, rem_in;
   logic [63:0]          quo_ff, quo_in;
   logic [DIV_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         num_in  = div_req.dividend;
         rem_in  = '0;
         quo_in  = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = div_req.cycles;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // restoring division, dividend consumed from the top
         for (int k = 0; k < DIV_STEPS; k++) begin
            rem_in = {rem_in[DIV_W-1:0], num_in[63]};
            num_in = {num_in[62:0], 1'b0};
            if (rem_in >= {1'b0, dvs_ff}) begin
               rem_in = rem_in - {1'b0, dvs_ff};
               quo_in = {quo_in[62:0], 1'b1};
            end else begin
               quo_in = {quo_in[62:0], 1'b0};
            end
         end
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

// ===== rtl/rmv_sqrt.sv =====
`default_nettype none

module rmv_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  rmv_pkg::sqrt_req_type sqrt_req,
   output rmv_pkg::sqrt_rsp_type sqrt_rsp
);
   import rmv_pkg::*;

   logic [63:0]           val_ff, val_in;
   logic [34:0]           rem_ff, rem_in;
   logic [31:0]           root_ff, root_in;
   logic [34:0]           trial;
   logic [SQRT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   always_comb begin
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      trial   = '0;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (sqrt_req.start) begin
         val_in  = sqrt_req.value;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = SQRT_CYCLES;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // bring down two radicand bits, try root*4+1
         for (int k = 0; k < SQRT_STEPS; k++) begin
            rem_in = {rem_in[32:0], val_in[63:62]};
            val_in = {val_in[61:0], 2'b00};
            trial  = {1'b0, root_in, 2'b01};
            if (rem_in >= trial) begin
               rem_in  = rem_in - trial;
               root_in = {root_in[30:0], 1'b1};
            end else begin
               root_in = {root_in[30:0], 1'b0};
            end
         end
         cnt_in = cnt_ff - SQRT_CNT_W'(1);
         if (cnt_ff == SQRT_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign sqrt_rsp.done = done_ff;
   assign sqrt_rsp.root = root_ff;

endmodule

`default_nettype wire

// ===== rtl/running_mean_variance_ci_top.sv =====
// Channel  Direction  Handshake            Beat
// req      in         req_valid/req_ready  one objective sample, signed Q16.16
// rsp      out        rsp_valid/rsp_ready  mean, stdev, interval, count, done flag
// csr      in         csr_valid/csr_ready  register index and write data
//
// Every sample goes through the shared divider (4 quotient bits a cycle, used for
// the mean step, the variance decay, var/n and the 1.96 scaling); every later one
// also goes through the square root unit (2 bits a cycle).
// req_ready is high only while the sequencer is idle; csr_ready is always high.
// Synchronous reset clears the count, mean and variance and sets stdev to all ones.
// A stalled rsp beat holds in its register; a finished item waits until it frees.
`default_nettype none

module running_mean_variance_ci_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [31:0]                  req_sample_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [31:0]                  rsp_mean_value,
   output logic [31:0]                         rsp_std_dev,
   output logic signed [31:0]                  rsp_interval_low,
   output logic signed [31:0]                  rsp_interval_high,
   output logic [rmv_pkg::CNT_OUT_BITS-1:0]    rsp_sample_count,
   output logic                                rsp_done_res,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rmv_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rmv_pkg::CSR_DATA_W-1:0]      csr_data
);
   import rmv_pkg::*;

   localparam logic [COUNT_BITS-1:0]   CNT_MAX     = '1;
   localparam logic [CNT_OUT_BITS-1:0] CNT_OUT_MAX = '1;

   state_type state_ff, state_in;

   logic [LEVEL_W-1:0]    level_a_ff, level_b_ff;
   logic [MIN_W-1:0]      min_ff;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] n_ff, n_in;
   logic signed [31:0]    mean_ff, mean_in;
   logic [63:0]           var_ff, var_in;
   logic [31:0]           stdev_ff, stdev_in;
   logic                  diff_neg_ff, diff_neg_in;
   logic [31:0]           ad_ff, ad_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic                  prod_en;
   logic [31:0]           sq_hi_ff, sq_hi_in;
   logic [PROD_W-1:0]     plo_ff, plo_in;
   logic [63:0]           term_ff, term_in;
   logic [63:0]           kept_ff, kept_in;
   logic [HALF_W-1:0]     half_ff, half_in;

   logic                     rsp_valid_ff;
   logic                     rsp_load;
   logic signed [31:0]       rsp_mean_ff, rsp_low_ff, rsp_high_ff;
   logic [31:0]              rsp_std_ff;
   logic [CNT_OUT_BITS-1:0]  rsp_count_ff;
   logic                     rsp_done_ff;

   div_req_type  div_req;
   div_rsp_type  div_rsp;
   sqrt_req_type sqrt_req;
   sqrt_rsp_type sqrt_rsp;

   // sample plus first-stage cost
   logic [21:0]        five_a, five_b;
   logic signed [33:0] sum_total;
   logic signed [31:0] total;
   logic signed [32:0] diff;
   logic [32:0]        diff_mag;
   logic [DIV_W-1:0]   n1_now, n1_held;

   // multiplier and variance arithmetic
   logic [31:0]        mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [TERM_W-1:0]  term_wide;
   logic [63:0]        term_val;
   logic [64:0]        var_sum;
   logic [63:0]        var_new;
   logic [31:0]        q_mag;
   logic [32:0]        mean_wide;

   // result forming
   logic [P196_W-1:0]       p196;
   logic [P196_W:0]         p392;
   logic [31:0]             abs_mean;
   logic signed [35:0]      low_wide, high_wide;
   logic [CMP_W-1:0]        count_ext;
   logic [CNT_OUT_BITS-1:0] cnt_out;
   logic                    done_now;

   assign five_a    = {1'b0, level_a_ff, 2'b00} + {3'b000, level_a_ff};
   assign five_b    = {1'b0, level_b_ff, 2'b00} + {3'b000, level_b_ff};
   assign sum_total = 34'(req_sample_value) + 34'(five_a) + 34'(five_b);
   assign total     = sat32(36'(sum_total));
   assign diff      = 33'(total) - 33'(mean_ff);
   assign diff_mag  = diff[32] ? (33'd0 - diff) : diff;
   assign n1_now    = DIV_W'(count_ff) + DIV_W'(1);
   assign n1_held   = DIV_W'(n_ff) + DIV_W'(1);

   assign prod_in   = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign term_wide = (TERM_W'(prod_ff) << 32) + TERM_W'(plo_ff);
   assign term_val  = (|term_wide[TERM_W-1:64]) ? '1 : term_wide[63:0];
   assign var_sum   = {1'b0, kept_ff} + {1'b0, term_ff};
   assign var_new   = var_sum[64] ? '1 : var_sum[63:0];
   assign q_mag     = div_rsp.quotient[31:0];
   assign mean_wide = diff_neg_ff ? (33'(mean_ff) - 33'(q_mag)) : (33'(mean_ff) + 33'(q_mag));

   assign p196      = P196_W'(stdev_ff) * P196_W'(HALF_MUL);
   assign p392      = {p196, 1'b0};
   assign abs_mean  = mean_ff[31] ? (32'd0 - mean_ff) : mean_ff;
   assign low_wide  = 36'(mean_ff) - 36'(half_ff);
   assign high_wide = 36'(mean_ff) + 36'(half_ff);
   assign count_ext = CMP_W'(count_ff);
   assign cnt_out   = (count_ext > CMP_W'(CNT_OUT_MAX)) ? CNT_OUT_MAX
                                                        : count_ext[CNT_OUT_BITS-1:0];
   assign done_now  = (count_ext >= CMP_W'(min_ff)) && (p392 <= (P196_W + 1)'(abs_mean));

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   rmv_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   rmv_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .sqrt_req (sqrt_req),
      .sqrt_rsp (sqrt_rsp)
   );

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      n_in        = n_ff;
      mean_in     = mean_ff;
      var_in      = var_ff;
      stdev_in    = stdev_ff;
      diff_neg_in = diff_neg_ff;
      ad_in       = ad_ff;
      sq_hi_in    = sq_hi_ff;
      plo_in      = plo_ff;
      term_in     = term_ff;
      kept_in     = kept_ff;
      half_in     = half_ff;
      prod_en     = 1'b0;
      mul_a       = '0;
      mul_b       = '0;
      rsp_load    = 1'b0;

      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = DIV_W'(n_ff);
      div_req.cycles   = DIV_CYC_64;
      sqrt_req.start   = 1'b0;
      sqrt_req.value   = div_rsp.quotient;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               n_in        = count_ff;
               count_in    = (count_ff != CNT_MAX) ? count_ff + COUNT_BITS'(1) : count_ff;
               diff_neg_in = diff[32];
               if (count_ff == '0) begin
                  // first sample only seeds the mean
                  mean_in  = total;
                  state_in = ST_HALF_GO;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = {diff_mag[31:0], 32'd0};
                  div_req.divisor  = n1_now;
                  div_req.cycles   = DIV_CYC_32;
                  state_in         = ST_DIV_MEAN;
               end
            end
         end
         ST_DIV_MEAN: begin
            if (div_rsp.done) begin
               mean_in  = mean_wide[31:0];
               ad_in    = q_mag;
               state_in = ST_MUL_SQ;
            end
         end
         ST_MUL_SQ: begin
            mul_a    = ad_ff;
            mul_b    = MUL_B_W'(ad_ff);
            prod_en  = 1'b1;
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            // square times (n+1), low half first
            sq_hi_in = prod_ff[63:32];
            mul_a    = prod_ff[31:0];
            mul_b    = MUL_B_W'(n1_held);
            prod_en  = 1'b1;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            plo_in   = prod_ff;
            mul_a    = sq_hi_ff;
            mul_b    = MUL_B_W'(n1_held);
            prod_en  = 1'b1;
            state_in = ST_TERM;
         end
         ST_TERM: begin
            term_in          = term_val;
            div_req.start    = 1'b1;
            div_req.dividend = var_ff;
            state_in         = ST_DIV_KEEP;
         end
         ST_DIV_KEEP: begin
            if (div_rsp.done) begin
               kept_in  = var_ff - div_rsp.quotient;
               state_in = ST_ADD_VAR;
            end
         end
         ST_ADD_VAR: begin
            var_in           = var_new;
            div_req.start    = 1'b1;
            div_req.dividend = var_new;
            state_in         = ST_DIV_STD;
         end
         ST_DIV_STD: begin
            if (div_rsp.done) begin
               sqrt_req.start = 1'b1;
               state_in       = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sqrt_rsp.done) begin
               stdev_in = sqrt_rsp.root;
               state_in = ST_HALF_GO;
            end
         end
         ST_HALF_GO: begin
            // 1.96*stdev as 196*stdev/100
            div_req.start    = 1'b1;
            div_req.dividend = {8'd0, p196, 16'd0};
            div_req.divisor  = DIV_W'(HALF_DIV);
            div_req.cycles   = DIV_CYC_48;
            state_in         = ST_DIV_HALF;
         end
         ST_DIV_HALF: begin
            if (div_rsp.done) begin
               half_in  = div_rsp.quotient[HALF_W-1:0];
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // hold until the output register frees
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         mean_ff      <= '0;
         var_ff       <= '0;
         stdev_ff     <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         mean_ff  <= mean_in;
         var_ff   <= var_in;
         stdev_ff <= stdev_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_a_ff <= LEVEL_RESET;
         level_b_ff <= LEVEL_RESET;
         min_ff     <= MIN_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LEVEL_A: begin
               level_a_ff <= csr_data[LEVEL_W-1:0];
            end
            CSR_LEVEL_B: begin
               level_b_ff <= csr_data[LEVEL_W-1:0];
            end
            CSR_MIN_SAMPLES: begin
               min_ff <= csr_data[MIN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      diff_neg_ff <= diff_neg_in;
      ad_ff       <= ad_in;
      sq_hi_ff    <= sq_hi_in;
      plo_ff      <= plo_in;
      term_ff     <= term_in;
      kept_ff     <= kept_in;
      half_ff     <= half_in;
      if (prod_en) begin
         prod_ff <= prod_in;
      end
      if (rsp_load) begin
         rsp_mean_ff  <= mean_ff;
         rsp_std_ff   <= stdev_ff;
         rsp_low_ff   <= sat32(low_wide);
         rsp_high_ff  <= sat32(high_wide);
         rsp_count_ff <= cnt_out;
         rsp_done_ff  <= done_now;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mean_value    = rsp_mean_ff;
   assign rsp_std_dev       = rsp_std_ff;
   assign rsp_interval_low  = rsp_low_ff;
   assign rsp_interval_high = rsp_high_ff;
   assign rsp_sample_count  = rsp_count_ff;
   assign rsp_done_res      = rsp_done_ff;

endmodule

`default_nettype wire

// ===== rtl/rmv_checker.sv =====
`default_nettype none

module rmv_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic signed [31:0]               rsp_mean_value,
   input logic [31:0]                      rsp_std_dev,
   input logic signed [31:0]               rsp_interval_low,
   input logic signed [31:0]               rsp_interval_high,
   input logic [rmv_pkg::CNT_OUT_BITS-1:0] rsp_sample_count,
   input logic                             rsp_done_res
);
   import rmv_pkg::*;

   logic [P196_W:0] std_x392;
   logic [31:0]     abs_mean;

   assign std_x392 = (P196_W + 1)'(rsp_std_dev) * (P196_W + 1)'(2 * HALF_MUL);
   assign abs_mean = rsp_mean_value[31] ? (32'd0 - rsp_mean_value) : rsp_mean_value;

   // an accepted sample keeps the sequencer busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready stayed high after a sample was taken");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mean_value) &&
      $stable(rsp_std_dev) && $stable(rsp_sample_count))
      else $error("stalled rsp beat changed");

   a_interval_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_interval_low <= rsp_mean_value &&
      rsp_interval_high >= rsp_mean_value)
      else $error("interval does not bracket the mean");

   a_done_precision: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> std_x392 <= (P196_W + 1)'(abs_mean))
      else $error("done raised without the precision condition");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sample_count != '0)
      else $error("result beat with zero sample count");

endmodule

bind running_mean_variance_ci_top rmv_checker u_rmv_checker (.*);

`default_nettype wire

// ===== test/running_mean_variance_ci_top_tb.sv =====
`timescale 1ns / 1ps

module running_mean_variance_ci_top_tb;
   import rmv_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;   // not a register

   localparam int WATCHDOG_LIMIT   = 10000;
   localparam int END_SETTLE       = 200;
   localparam int LONG_HOLD_AT     = 300;
   localparam int LONG_HOLD_CYCLES = 1000;
   localparam int RANDOM_PHASES    = 8;
   localparam int PHASE_SAMPLES    = 125;

   typedef enum logic [1:0] {
      OP_SAMPLE,
      OP_CSR,
      OP_DRAIN
   } plan_kind_type;

   typedef struct {
      plan_kind_type          kind;
      logic [CSR_INDEX_W-1:0] index;
      logic [31:0]            value;
   } plan_type;

   typedef struct {
      logic signed [31:0]       mean;
      logic [31:0]              stdev;
      logic signed [31:0]       low;
      logic signed [31:0]       high;
      logic [CNT_OUT_BITS-1:0]  count;
      logic                     done;
   } stats_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [31:0]       req_sample_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [31:0]       rsp_mean_value;
   logic [31:0]              rsp_std_dev;
   logic signed [31:0]       rsp_interval_low;
   logic signed [31:0]       rsp_interval_high;
   logic [CNT_OUT_BITS-1:0]  rsp_sample_count;
   logic                     rsp_done_res;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_data = '0;

   running_mean_variance_ci_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample_value  (req_sample_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_mean_value    (rsp_mean_value),
      .rsp_std_dev       (rsp_std_dev),
      .rsp_interval_low  (rsp_interval_low),
      .rsp_interval_high (rsp_interval_high),
      .rsp_sample_count  (rsp_sample_count),
      .rsp_done_res      (rsp_done_res),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   plan_type  plan_q[$];
   stats_type stats_due_q[$];

   // running statistics as the block should hold them
   logic [COUNT_BITS-1:0] acc_count;
   longint                acc_mean;
   logic [63:0]           acc_var;
   logic [31:0]           acc_stdev;
   logic [LEVEL_W-1:0]    cfg_level_a;
   logic [LEVEL_W-1:0]    cfg_level_b;
   logic [MIN_W-1:0]      cfg_min_samples;

   int mismatches    = 0;
   int beats_checked = 0;

   function automatic longint clip_s32(input longint v);
      if (v > 64'sd2147483647) begin
         return 64'sd2147483647;
      end else if (v < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic logic [31:0] root_floor(input logic [63:0] v);
      logic [31:0] root;
      logic [63:0] cand;
      root = '0;
      for (int i = 31; i >= 0; i--) begin
         cand = {32'd0, root | (32'd1 << i)};
         if (cand * cand <= v) begin
            root = cand[31:0];
         end
      end
      return root;
   endfunction

   task automatic apply_csr(input logic [CSR_INDEX_W-1:0] index, input logic [31:0] value);
      case (index)
         CSR_LEVEL_A:     cfg_level_a = value[LEVEL_W-1:0];
         CSR_LEVEL_B:     cfg_level_b = value[LEVEL_W-1:0];
         CSR_MIN_SAMPLES: cfg_min_samples = value[MIN_W-1:0];
         default: ;
      endcase
   endtask

   // advance the running statistics by one sample and queue the beat it yields
   task automatic fold_sample(input logic signed [31:0] sample);
      longint      total;
      longint      prev;
      longint      delta;
      longint      mag;
      logic [63:0] n;
      logic [63:0] abs_step;
      logic [63:0] sq;
      logic [63:0] term;
      logic [63:0] kept;
      logic [127:0] wide;
      logic [64:0] sum;
      logic [39:0] half;
      stats_type   s;
      total = clip_s32(longint'(sample) + 5 * longint'(cfg_level_a)
                       + 5 * longint'(cfg_level_b));
      n = 64'(acc_count);
      if (n == 0) begin
         acc_mean = total;
      end else begin
         prev = acc_mean;
         acc_mean = prev + (total - prev) / longint'(n + 1);
         delta = acc_mean - prev;
         abs_step = (delta < 0) ? 64'(-delta) : 64'(delta);
         sq = abs_step * abs_step;
         wide = 128'(sq) * 128'(n + 1);
         term = (wide[127:64] != 0) ? '1 : wide[63:0];
         kept = acc_var - acc_var / n;
         sum = 65'(kept) + 65'(term);
         acc_var = sum[64] ? '1 : sum[63:0];
         acc_stdev = root_floor(acc_var / n);
      end
      if (acc_count != '1) begin
         acc_count = acc_count + COUNT_BITS'(1);
      end
      half = (40'd196 * 40'(acc_stdev)) / 40'd100;
      mag = (acc_mean < 0) ? -acc_mean : acc_mean;
      s.mean  = acc_mean[31:0];
      s.stdev = acc_stdev;
      s.low   = 32'(clip_s32(acc_mean - longint'(half)));
      s.high  = 32'(clip_s32(acc_mean + longint'(half)));
      s.count = (64'(acc_count) > ((64'd1 << CNT_OUT_BITS) - 64'd1)) ? '1
                                                                     : CNT_OUT_BITS'(acc_count);
      s.done  = (acc_count >= cfg_min_samples) &&
                ((64'd392 * 64'(acc_stdev)) <= 64'(mag));
      stats_due_q.push_back(s);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("mismatch at beat %0d, %s: got %h, want %h", beats_checked, what, got, want);
   endtask

   task automatic push_sample(input logic [31:0] value);
      plan_type p;
      p.kind  = OP_SAMPLE;
      p.index = '0;
      p.value = value;
      plan_q.push_back(p);
   endtask

   task automatic push_csr(input logic [CSR_INDEX_W-1:0] index, input logic [31:0] value);
      plan_type p;
      p.kind  = OP_CSR;
      p.index = index;
      p.value = value;
      plan_q.push_back(p);
   endtask

   task automatic push_drain();
      plan_type p;
      p.kind  = OP_DRAIN;
      p.index = '0;
      p.value = '0;
      plan_q.push_back(p);
   endtask

   function automatic logic [31:0] pick_level();
      case ($urandom_range(0, 4))
         0:       return 32'd0;
         1:       return 32'd327680;
         2:       return 32'hFFFF_FFFF;         // masks to the largest level
         3:       return $urandom;
         default: return $urandom_range(0, 327680);
      endcase
   endfunction

   function automatic logic [31:0] pick_min();
      case ($urandom_range(0, 4))
         0:       return 32'd1;
         1:       return 32'h00FF_FFFF;
         2:       return $urandom_range(0, 2000);
         3:       return $urandom;
         default: return 32'd0;
      endcase
   endfunction

   // stimulus plan
   initial begin
      logic [31:0] center;
      logic [31:0] noise;
      int          spread;
      int          r;

      // saturating totals with levels of 5.0 and above and a zero minimum
      push_csr(CSR_LEVEL_A, 32'hFFFF_FFFF);
      push_csr(CSR_LEVEL_B, 32'h0005_0000);
      push_csr(CSR_MIN_SAMPLES, 32'h0000_0000);
      push_csr(CSR_SPARE, 32'hFFFF_FFFF);
      push_sample(32'h7FFF_FFFF);
      push_sample(32'h7FF0_0000);
      push_sample(32'h7FFF_FFF0);
      push_sample(32'h7FF8_1234);
      push_sample(32'h7FFF_FFFF);
      push_sample(32'h7F00_0000);
      push_sample(32'h7FC0_0000);
      push_drain();

      // field extremes with no fixed cost and the largest minimum
      push_csr(CSR_LEVEL_A, 32'h0000_0000);
      push_csr(CSR_LEVEL_B, 32'h0000_0000);
      push_csr(CSR_MIN_SAMPLES, 32'hFFFF_FFFF);
      push_sample(32'h8000_0000);
      push_sample(32'h0000_0000);
      push_sample(32'hFFFF_FFFF);
      push_sample(32'h0000_0001);
      push_sample(32'h5555_5555);
      push_sample(32'hAAAA_AAAA);
      push_sample(32'h7FFF_FFFF);
      push_sample(32'h8000_0000);
      push_sample(32'h0000_FFFF);
      push_sample(32'hFFFF_0000);

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         push_drain();
         push_csr(CSR_LEVEL_A, pick_level());
         push_csr(CSR_LEVEL_B, pick_level());
         push_csr(CSR_MIN_SAMPLES, pick_min());
         if ($urandom_range(0, 3) == 0) begin
            push_csr(CSR_SPARE, $urandom);
         end
         center = $urandom;
         spread = $urandom_range(0, 24);
         for (int k = 0; k < PHASE_SAMPLES; k++) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               noise = $urandom & ((32'd1 << spread) - 1);
               push_sample($urandom_range(0, 1) ? center + noise : center - noise);
            end else if (r < 90) begin
               push_sample($urandom);
            end else begin
               case ($urandom_range(0, 3))
                  0:       push_sample(32'h7FFF_FFFF);
                  1:       push_sample(32'h8000_0000);
                  2:       push_sample(32'h0000_0000);
                  default: push_sample(32'hFFFF_FFFF);
               endcase
            end
            // pause the sender until the block has drained
            if (k == PHASE_SAMPLES / 2 && ph % 3 == 1) begin
               push_drain();
            end
         end
      end

      do @(posedge clock); while (plan_q.size() != 0 || stats_due_q.size() != 0);
      repeat (END_SETTLE) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // driver
   int gap_left   = 0;
   int burst_left = 1;

   always @(posedge clock) begin
      logic offer_req;
      logic offer_csr;
      offer_req = 1'b0;
      offer_csr = 1'b0;
      if (reset) begin
         req_valid        <= 1'b0;
         req_sample_value <= '0;
         csr_valid        <= 1'b0;
         csr_index        <= '0;
         csr_data         <= '0;
         cfg_level_a      = LEVEL_RESET;
         cfg_level_b      = LEVEL_RESET;
         cfg_min_samples  = MIN_RESET;
         acc_count        = '0;
         acc_mean         = 0;
         acc_var          = '0;
         acc_stdev        = '1;
      end else begin
         if (req_valid && req_ready) begin
            fold_sample(req_sample_value);
            void'(plan_q.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
            end
         end
         if (csr_valid && csr_ready) begin
            apply_csr(csr_index, csr_data);
            void'(plan_q.pop_front());
         end

         if (req_valid && !req_ready) begin
            offer_req = 1'b1;                  // hold the beat
         end else if (csr_valid && !csr_ready) begin
            offer_csr = 1'b1;
         end else if (plan_q.size() != 0) begin
            case (plan_q[0].kind)
               OP_SAMPLE: begin
                  if (gap_left > 0) begin
                     gap_left--;
                  end else begin
                     offer_req = 1'b1;
                  end
               end
               OP_CSR: offer_csr = 1'b1;
               default: begin
                  if (stats_due_q.size() == 0) begin
                     void'(plan_q.pop_front());
                  end
               end
            endcase
         end

         req_valid <= offer_req;
         if (offer_req) begin
            req_sample_value <= plan_q[0].value;
         end
         csr_valid <= offer_csr;
         if (offer_csr) begin
            csr_index <= plan_q[0].index;
            csr_data  <= plan_q[0].value;
         end
      end
   end

   // monitor and checker
   int hold_left    = 0;
   int stall_window = 0;
   int stall_mode   = 0;

   always @(posedge clock) begin
      stats_type want;
      logic      nxt_ready;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            beats_checked++;
            if (stats_due_q.size() == 0) begin
               report_mismatch("unexpected beat, mean_value", rsp_mean_value, 32'd0);
            end else begin
               want = stats_due_q.pop_front();
               if (rsp_mean_value !== want.mean)
                  report_mismatch("mean_value", rsp_mean_value, want.mean);
               if (rsp_std_dev !== want.stdev)
                  report_mismatch("std_dev", rsp_std_dev, want.stdev);
               if (rsp_interval_low !== want.low)
                  report_mismatch("interval_low", rsp_interval_low, want.low);
               if (rsp_interval_high !== want.high)
                  report_mismatch("interval_high", rsp_interval_high, want.high);
               if (rsp_sample_count !== want.count)
                  report_mismatch("sample_count", 32'(rsp_sample_count), 32'(want.count));
               if (rsp_done_res !== want.done)
                  report_mismatch("done_res", 32'(rsp_done_res), 32'(want.done));
            end
            // hold off long enough for the block to fill and stall its input
            if (beats_checked == LONG_HOLD_AT) begin
               hold_left = LONG_HOLD_CYCLES;
            end
         end

         if (hold_left > 0) begin
            hold_left--;
            nxt_ready = 1'b0;
         end else begin
            if (stall_window <= 0) begin
               stall_mode = $urandom_range(0, 3);
               stall_window = $urandom_range(20, 300);
            end else begin
               stall_window--;
            end
            case (stall_mode)
               2:       nxt_ready = 1'($urandom_range(0, 1));
               3:       nxt_ready = ($urandom_range(0, 7) == 0);
               default: nxt_ready = 1'b1;
            endcase
         end
         rsp_ready <= nxt_ready;
      end
   end

   // watchdog on cycles with no beat on any channel
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

endmodule
